/* rtl/npmm_pkg.sv */
// ---------------------------------------------------------------------------
// npmm_pkg: shared types and constants of the negacyclic polynomial multiplier
// Holds the request and result structs, mode and register codes, store sizes
// and the sequencer state type.
// ---------------------------------------------------------------------------
package npmm_pkg;

  // Store geometry.
  localparam int NUM_COEFFS = 256;
  localparam int PROD_LEN   = 2 * NUM_COEFFS - 1;
  localparam int ADDR_W     = $clog2(NUM_COEFFS);
  localparam int PADDR_W    = $clog2(PROD_LEN);

  // Width of the coefficient data path and of the remainder unit dividend.
  localparam int COEF_W    = 32;
  localparam int DVD_W     = 64;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  // Request modes.
  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_COMPUTE = 2'd1;
  localparam logic [1:0] MODE_READ    = 2'd2;

  // Configuration register indexes.
  localparam logic REG_MODULUS    = 1'b0;
  localparam logic REG_ACCUMULATE = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  index;
    logic [31:0] a_coef;
    logic [31:0] b_coef;
    logic [31:0] acc_coef;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  out_index;
    logic [31:0] result_coef;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MAC_RD,
    ST_MAC_MUL,
    ST_MAC_ADD,
    ST_MAC_DIV,
    ST_FOLD_RD,
    ST_FOLD_LO,
    ST_FOLD_SUM,
    ST_FOLD_DIV
  } state_t;

endpackage

/* rtl/npmm_ram.sv */
// ---------------------------------------------------------------------------
// npmm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module npmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/npmm_rem.sv */
// ---------------------------------------------------------------------------
// npmm_rem: bit-serial 64-by-32 remainder unit
// Restoring division, one dividend bit per cycle. A zero divisor yields zero.
// ---------------------------------------------------------------------------
module npmm_rem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [npmm_pkg::DVD_W-1:0]   dividend,
  input  logic [npmm_pkg::COEF_W-1:0]  divisor,
  output logic                         done,
  output logic [npmm_pkg::COEF_W-1:0]  rem
);

  logic                              run_r, run_nxt;
  logic                              done_r, done_nxt;
  logic [npmm_pkg::DIV_CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [npmm_pkg::DVD_W-1:0]        dvd_r, dvd_nxt;
  logic [npmm_pkg::COEF_W-1:0]       rem_r, rem_nxt;
  logic [npmm_pkg::COEF_W:0]         trial;

  // One restoring step per cycle while running.
  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[npmm_pkg::DVD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      trial = trial - {1'b0, divisor};
    end
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      rem_nxt = '0;
    end else if (run_r) begin
      rem_nxt = trial[npmm_pkg::COEF_W-1:0];
      dvd_nxt = {dvd_r[npmm_pkg::DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == npmm_pkg::DIV_CNT_W'(npmm_pkg::DVD_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state is reset; the data path is not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = (divisor == '0) ? '0 : rem_r;

  // A new operation never starts on top of a running one.
  assert property (@(posedge clk) disable iff (!rst_n) start |-> !run_r)
    else $error("remainder unit started while busy");

  // Completion ends the run.
  assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !run_r)
    else $error("remainder done while still running");

  // A finished remainder is below a nonzero divisor.
  assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && divisor != '0) |-> (rem_r < divisor))
    else $error("remainder not reduced");

endmodule

/* rtl/negacyclic_poly_mul_mod.sv */
// ---------------------------------------------------------------------------
// negacyclic_poly_mul_mod: schoolbook multiplier in Z_q[x]/(x^N+1)
// Loads operand and accumulator coefficients, forms the negacyclic product
// into the accumulator and returns single accumulator coefficients.
// ---------------------------------------------------------------------------
// A load request is written in the cycle that takes it; a read request's
// result is strobed on out_valid for one cycle, in the cycle after it is
// taken; the receiver cannot stall. A compute request keeps busy high until
// every coefficient pair is multiplied and every fold step is done. Each
// pair takes a memory read, a 32x32 multiply, an add and the 64-step
// bit-serial remainder unit, which sets the rate; each fold step reads, sums and uses the same unit.
// Configuration is taken at any time on the cfg_ port (always ready).
module negacyclic_poly_mul_mod (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  npmm_pkg::in_req_t    in_data,
  output logic                 out_valid,
  output npmm_pkg::out_res_t   out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam logic [npmm_pkg::ADDR_W-1:0] LAST = npmm_pkg::ADDR_W'(npmm_pkg::NUM_COEFFS - 1);

  npmm_pkg::state_t                   state_r, state_nxt;
  logic [npmm_pkg::ADDR_W-1:0]        i_r, i_nxt;
  logic [npmm_pkg::ADDR_W-1:0]        j_r, j_nxt;
  logic [npmm_pkg::DVD_W-1:0]         mul_r, mul_nxt;
  logic [npmm_pkg::COEF_W-1:0]        psum_r, psum_nxt;
  logic [npmm_pkg::COEF_W-1:0]        phi_r, phi_nxt;
  logic [npmm_pkg::COEF_W-1:0]        accv_r, accv_nxt;
  logic [7:0]                         idx_r, idx_nxt;
  logic                               inr_r, inr_nxt;
  logic [npmm_pkg::NUM_COEFFS-1:0]    vld_r, vld_nxt;
  logic [31:0]                        modulus_r;
  logic                               accum_r;

  logic                               accepted, in_range;
  logic [npmm_pkg::ADDR_W-1:0]        in_addr;
  logic [npmm_pkg::PADDR_W-1:0]       pos;
  logic                               first;

  logic                               ab_we;
  logic [npmm_pkg::ADDR_W-1:0]        a_raddr, b_raddr;
  logic [npmm_pkg::COEF_W-1:0]        a_rd, b_rd;
  logic                               p_we;
  logic [npmm_pkg::PADDR_W-1:0]       p_waddr, p_raddr;
  logic [npmm_pkg::COEF_W-1:0]        p_wdata, p_rd;
  logic                               acc_we;
  logic [npmm_pkg::ADDR_W-1:0]        acc_waddr, acc_raddr;
  logic [npmm_pkg::COEF_W-1:0]        acc_wdata, acc_rd;

  logic                               div_start, div_done;
  logic [npmm_pkg::DVD_W-1:0]         div_dvd;
  logic [npmm_pkg::COEF_W-1:0]        div_rem;

  assign accepted  = start && !busy;
  assign in_range  = {24'b0, in_data.index} < 32'(npmm_pkg::NUM_COEFFS);
  assign in_addr   = npmm_pkg::ADDR_W'(in_data.index);
  assign pos       = npmm_pkg::PADDR_W'(i_r) + npmm_pkg::PADDR_W'(j_r);
  assign first     = (i_r == '0) || (j_r == LAST);
  assign cfg_ready = 1'b1;
  assign busy      = (state_r != npmm_pkg::ST_IDLE);

  // Sequencer: next state, memory ports and data path registers.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    mul_nxt   = mul_r;
    psum_nxt  = psum_r;
    phi_nxt   = phi_r;
    accv_nxt  = accv_r;
    idx_nxt   = idx_r;
    inr_nxt   = inr_r;
    vld_nxt   = vld_r;
    ab_we     = 1'b0;
    a_raddr   = i_r;
    b_raddr   = j_r;
    p_we      = 1'b0;
    p_waddr   = pos;
    p_wdata   = div_rem;
    p_raddr   = pos;
    acc_we    = 1'b0;
    acc_waddr = i_r;
    acc_wdata = div_rem;
    acc_raddr = i_r;
    div_start = 1'b0;
    div_dvd   = mul_r + {32'b0, psum_r};
    out_valid = 1'b0;
    out_data.out_index   = idx_r;
    out_data.result_coef = (inr_r && vld_r[acc_raddr]) ? acc_rd : '0;

    case (state_r)
      npmm_pkg::ST_IDLE: begin
        acc_raddr = in_addr;
        acc_waddr = in_addr;
        acc_wdata = in_data.acc_coef;
        if (accepted) begin
          case (in_data.mode)
            npmm_pkg::MODE_LOAD: begin
              if (in_range) begin
                ab_we   = 1'b1;
                acc_we  = 1'b1;
                vld_nxt[in_addr] = 1'b1;
              end
            end
            npmm_pkg::MODE_COMPUTE: begin
              i_nxt     = '0;
              j_nxt     = '0;
              state_nxt = npmm_pkg::ST_MAC_RD;
            end
            npmm_pkg::MODE_READ: begin
              idx_nxt   = in_data.index;
              inr_nxt   = in_range;
              i_nxt     = in_addr;
              state_nxt = npmm_pkg::ST_READ;
            end
            default: begin
            end
          endcase
        end
      end
      // Read data is out of the accumulator memory: strobe the result.
      npmm_pkg::ST_READ: begin
        out_valid = 1'b1;
        state_nxt = npmm_pkg::ST_IDLE;
      end
      // Multiply-accumulate of one coefficient pair.
      npmm_pkg::ST_MAC_RD: begin
        state_nxt = npmm_pkg::ST_MAC_MUL;
      end
      npmm_pkg::ST_MAC_MUL: begin
        mul_nxt   = {32'b0, a_rd} * {32'b0, b_rd};
        psum_nxt  = first ? '0 : p_rd;
        state_nxt = npmm_pkg::ST_MAC_ADD;
      end
      npmm_pkg::ST_MAC_ADD: begin
        div_start = 1'b1;
        state_nxt = npmm_pkg::ST_MAC_DIV;
      end
      npmm_pkg::ST_MAC_DIV: begin
        if (div_done) begin
          p_we = 1'b1;
          if (j_r == LAST) begin
            j_nxt = '0;
            if (i_r == LAST) begin
              i_nxt     = '0;
              state_nxt = npmm_pkg::ST_FOLD_RD;
            end else begin
              i_nxt     = i_r + 1'b1;
              state_nxt = npmm_pkg::ST_MAC_RD;
            end
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = npmm_pkg::ST_MAC_RD;
          end
        end
      end
      // Fold step: read the upper product term and the accumulator.
      npmm_pkg::ST_FOLD_RD: begin
        p_raddr   = npmm_pkg::PADDR_W'(i_r) + npmm_pkg::PADDR_W'(npmm_pkg::NUM_COEFFS);
        state_nxt = npmm_pkg::ST_FOLD_LO;
      end
      npmm_pkg::ST_FOLD_LO: begin
        p_raddr   = npmm_pkg::PADDR_W'(i_r);
        phi_nxt   = (i_r == LAST) ? '0 : p_rd;
        accv_nxt  = (accum_r && vld_r[i_r]) ? acc_rd : '0;
        state_nxt = npmm_pkg::ST_FOLD_SUM;
      end
      // q - p[k+N] + p[k] + c[k]; the added q vanishes in the reduction.
      npmm_pkg::ST_FOLD_SUM: begin
        div_dvd   = {32'b0, modulus_r} - {32'b0, phi_r} + {32'b0, p_rd} + {32'b0, accv_r};
        div_start = 1'b1;
        state_nxt = npmm_pkg::ST_FOLD_DIV;
      end
      npmm_pkg::ST_FOLD_DIV: begin
        if (div_done) begin
          acc_we       = 1'b1;
          vld_nxt[i_r] = 1'b1;
          if (i_r == LAST) begin
            i_nxt     = '0;
            state_nxt = npmm_pkg::ST_IDLE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = npmm_pkg::ST_FOLD_RD;
          end
        end
      end
      default: begin
        state_nxt = npmm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= npmm_pkg::ST_IDLE;
      i_r       <= '0;
      j_r       <= '0;
      vld_r     <= '0;
      modulus_r <= 32'd2;
      accum_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      vld_r   <= vld_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          npmm_pkg::REG_MODULUS:    modulus_r <= cfg_data;
          npmm_pkg::REG_ACCUMULATE: accum_r   <= cfg_data[0];
          default: begin
          end
        endcase
      end
    end
  end

  // Data path registers.
  always_ff @(posedge clk) begin
    mul_r  <= mul_nxt;
    psum_r <= psum_nxt;
    phi_r  <= phi_nxt;
    accv_r <= accv_nxt;
    idx_r  <= idx_nxt;
    inr_r  <= inr_nxt;
  end

  // Coefficient stores.
  npmm_ram #(.WIDTH(npmm_pkg::COEF_W), .DEPTH(npmm_pkg::NUM_COEFFS)) u_a_ram (
    .clk(clk), .we(ab_we), .waddr(in_addr), .wdata(in_data.a_coef),
    .raddr(a_raddr), .rdata(a_rd)
  );

  npmm_ram #(.WIDTH(npmm_pkg::COEF_W), .DEPTH(npmm_pkg::NUM_COEFFS)) u_b_ram (
    .clk(clk), .we(ab_we), .waddr(in_addr), .wdata(in_data.b_coef),
    .raddr(b_raddr), .rdata(b_rd)
  );

  npmm_ram #(.WIDTH(npmm_pkg::COEF_W), .DEPTH(npmm_pkg::NUM_COEFFS)) u_acc_ram (
    .clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
    .raddr(acc_raddr), .rdata(acc_rd)
  );

  npmm_ram #(.WIDTH(npmm_pkg::COEF_W), .DEPTH(npmm_pkg::PROD_LEN)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rd)
  );

  // Shared modular reduction.
  npmm_rem u_rem (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(modulus_r), .done(div_done), .rem(div_rem)
  );

  // A result strobe lasts one cycle.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // An accepted compute request keeps the block busy.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accepted && in_data.mode == npmm_pkg::MODE_COMPUTE) |=> busy)
    else $error("compute request did not start");

  // Product memory writes only happen when the remainder unit finishes.
  assert property (@(posedge clk) disable iff (!rst_n) p_we |-> div_done)
    else $error("product write without a finished reduction");

  // Loads never happen during a computation.
  assert property (@(posedge clk) disable iff (!rst_n) ab_we |-> !busy)
    else $error("operand write while busy");

endmodule
